### src/frgf_pkg.sv
package frgf_pkg;

    // Field and address widths
    localparam int ADDR_W    = 24;
    localparam int BYTE_W    = 8;
    localparam int FONT_W    = 3;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 2;
    localparam int NUM_FONTS = 5;
    localparam int CFG_IDX_W = 3;
    localparam int GB_IDX_W  = 13;
    localparam int OFFSET_W  = 18;

    // Item commands
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RX_BYTE = 1'b1;

    // Font codes, which are also the base register indexes
    localparam logic [FONT_W-1:0] FONT_GB2312_16   = 3'd0;
    localparam logic [FONT_W-1:0] FONT_ASCII_5X7   = 3'd1;
    localparam logic [FONT_W-1:0] FONT_ASCII_7X8   = 3'd2;
    localparam logic [FONT_W-1:0] FONT_ASCII_8X16  = 3'd3;
    localparam logic [FONT_W-1:0] FONT_ASCII_BOLD  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNEXPECTED = 2'd2;

    // Flash bytes
    localparam logic [BYTE_W-1:0] FLASH_READ_CMD = 8'h03;
    localparam logic [BYTE_W-1:0] FLASH_DUMMY    = 8'hFF;

    // GB2312 code ranges and table layout
    localparam logic [BYTE_W-1:0] GB_LO_MIN    = 8'hA1;
    localparam logic [BYTE_W-1:0] GB_SYM_FIRST = 8'hA1;
    localparam logic [BYTE_W-1:0] GB_SYM_LAST  = 8'hA3;
    localparam logic [BYTE_W-1:0] GB_EXT_ROW   = 8'hA9;
    localparam logic [BYTE_W-1:0] GB_HZ_FIRST  = 8'hB0;
    localparam logic [BYTE_W-1:0] GB_HZ_LAST   = 8'hF7;
    localparam logic [GB_IDX_W-1:0] GB_EXT_START = 13'd282;
    localparam logic [GB_IDX_W-1:0] GB_ROW_LEN   = 13'd94;
    localparam logic [GB_IDX_W-1:0] GB_HZ_START  = 13'd846;

    // ASCII code range
    localparam logic [BYTE_W-1:0] ASCII_FIRST = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_LAST  = 8'h7F;

    // Glyph lengths in bytes
    localparam logic [COUNT_W-1:0] LEN_GB    = 6'd32;
    localparam logic [COUNT_W-1:0] LEN_SMALL = 6'd8;
    localparam logic [COUNT_W-1:0] LEN_LARGE = 6'd16;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    typedef logic [NUM_FONTS-1:0][ADDR_W-1:0] base_bank_t;

    typedef struct packed {
        logic                cmd;
        logic [FONT_W-1:0]   font_select;
        logic [BYTE_W-1:0]   first_byte;
        logic [BYTE_W-1:0]   second_byte;
        logic                invert;
        logic [BYTE_W-1:0]   rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                tx_valid;
        logic [BYTE_W-1:0]   tx_byte;
        logic                select_active;
        logic                data_valid;
        logic [BYTE_W-1:0]   glyph_byte;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] len;
    } lookup_t;

endpackage

### src/frgf_lookup.sv
module frgf_lookup
    import frgf_pkg::*;
(
    input  logic [FONT_W-1:0] font,
    input  logic [BYTE_W-1:0] hi,
    input  logic [BYTE_W-1:0] lo,
    input  base_bank_t        bases,
    output lookup_t           result
);

    logic                gb_lo_ok;
    logic                gb_sym;
    logic                gb_ext;
    logic                gb_hz;
    logic                gb_ok;
    logic                ascii_ok;
    logic [BYTE_W-1:0]   row_off;
    logic [GB_IDX_W-1:0] lo_off;
    logic [GB_IDX_W-1:0] row_start;
    logic [GB_IDX_W-1:0] gb_idx;
    logic [6:0]          ascii_idx;
    logic [OFFSET_W-1:0] offset;
    logic [ADDR_W-1:0]   base;
    logic                ascii_short;

    // Classify the GB2312 code
    assign gb_lo_ok = lo >= GB_LO_MIN;
    assign gb_ext   = hi == GB_EXT_ROW;
    assign gb_sym   = (hi >= GB_SYM_FIRST) && (hi <= GB_SYM_LAST);
    assign gb_hz    = (hi >= GB_HZ_FIRST) && (hi <= GB_HZ_LAST);
    assign gb_ok    = gb_lo_ok && (gb_ext || gb_sym || gb_hz);
    assign ascii_ok = (hi >= ASCII_FIRST) && (hi <= ASCII_LAST);

    // Form the GB2312 glyph index: area start plus row times row length plus column
    assign row_off   = gb_sym ? (hi - GB_SYM_FIRST) : (hi - GB_HZ_FIRST);
    assign lo_off    = GB_IDX_W'(lo - GB_LO_MIN);
    assign row_start = GB_IDX_W'(row_off[6:0]) * GB_ROW_LEN;
    always_comb begin
        if (gb_ext) begin
            gb_idx = GB_EXT_START + lo_off;
        end else if (gb_hz) begin
            gb_idx = row_start + lo_off + GB_HZ_START;
        end else begin
            gb_idx = row_start + lo_off;
        end
    end

    // ASCII index from the printable range
    assign ascii_idx   = 7'(hi - ASCII_FIRST);
    assign ascii_short = (font == FONT_ASCII_5X7) || (font == FONT_ASCII_7X8);

    // Pick offset, length and base by font, then add the base
    always_comb begin
        result.valid = 1'b0;
        result.len   = '0;
        offset       = '0;
        base         = '0;
        unique case (font)
            FONT_GB2312_16: begin
                result.valid = gb_ok;
                result.len   = LEN_GB;
                offset       = {gb_idx, 5'b0};
                base         = bases[FONT_GB2312_16];
            end
            FONT_ASCII_5X7, FONT_ASCII_7X8, FONT_ASCII_8X16, FONT_ASCII_BOLD: begin
                result.valid = ascii_ok;
                result.len   = ascii_short ? LEN_SMALL : LEN_LARGE;
                offset       = ascii_short ? OFFSET_W'({ascii_idx, 3'b0})
                                           : OFFSET_W'({ascii_idx, 4'b0});
                base         = bases[font];
            end
            default: begin
                result.valid = 1'b0;
            end
        endcase
        result.addr = base + ADDR_W'(offset);
    end

endmodule

### src/frgf_out_buf.sv
module frgf_out_buf
    import frgf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t push_data,
    output logic      has_room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    out_item_t  entry_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign has_room = count_reg != 2'd2;
    assign m_valid  = count_reg != 2'd0;
    assign m_data   = entry_reg[rd_ptr_reg];
    assign pop      = m_valid && m_ready;

    // Store each finished item
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### src/font_rom_glyph_fetch_core.sv
// Each accepted input item's result is written into the output buffer registers.
// Throughput: one item per cycle; a two-entry output buffer keeps s_ready high
// until two results wait on m_ready.
// Reset: aresetn (synchronous, active low) clears the sequencer, the base
// registers and the output buffer; no clearing pass is needed.
module font_rom_glyph_fetch_core
    import frgf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    base_bank_t         base_reg;
    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [COUNT_W-1:0] len_reg;
    logic [COUNT_W-1:0] len_next;
    logic               inv_reg;
    logic               inv_next;
    out_item_t          result;
    lookup_t            lookup;
    logic               accept;
    logic [COUNT_W-1:0] count_inc;
    logic [BYTE_W-1:0]  glyph;
    logic [BYTE_W-1:0]  addr_byte;
    logic               data_done;

    assign accept = s_valid && s_ready;

    // Base address registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_FONTS))) begin
            base_reg[cfg_index] <= cfg_data;
        end
    end

    frgf_lookup u_lookup (
        .font   (s_data.font_select),
        .hi     (s_data.first_byte),
        .lo     (s_data.second_byte),
        .bases  (base_reg),
        .result (lookup)
    );

    assign count_inc = count_reg + COUNT_W'(1);
    assign data_done = count_inc >= len_reg;
    assign glyph     = inv_reg ? ~s_data.rx_byte : s_data.rx_byte;

    // Address byte for the header step, high byte first
    always_comb begin
        case (count_reg[1:0])
            2'd0:    addr_byte = addr_reg[23:16];
            2'd1:    addr_byte = addr_reg[15:8];
            default: addr_byte = addr_reg[7:0];
        endcase
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        inv_next   = inv_reg;
        if (s_data.cmd == CMD_REQUEST) begin
            if (phase_reg == PH_IDLE && lookup.valid) begin
                phase_next = PH_HEADER;
                count_next = '0;
                addr_next  = lookup.addr;
                len_next   = lookup.len;
                inv_next   = s_data.invert;
            end
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (count_reg < COUNT_W'(3)) begin
                        count_next = count_inc;
                    end else begin
                        count_next = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (data_done) begin
                        count_next = '0;
                        phase_next = PH_IDLE;
                    end else begin
                        count_next = count_inc;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result item
    always_comb begin
        result = '0;
        if (s_data.cmd == CMD_REQUEST) begin
            if (phase_reg != PH_IDLE) begin
                result.status        = STATUS_UNEXPECTED;
                result.select_active = 1'b1;
            end else if (!lookup.valid) begin
                result.status = STATUS_INVALID;
            end else begin
                result.tx_valid      = 1'b1;
                result.tx_byte       = FLASH_READ_CMD;
                result.select_active = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    result.tx_valid      = 1'b1;
                    result.select_active = 1'b1;
                    result.tx_byte       = (count_reg < COUNT_W'(3)) ? addr_byte
                                                                     : FLASH_DUMMY;
                end
                PH_DATA: begin
                    result.data_valid = 1'b1;
                    result.glyph_byte = glyph;
                    if (data_done) begin
                        result.last = 1'b1;
                    end else begin
                        result.tx_valid      = 1'b1;
                        result.tx_byte       = FLASH_DUMMY;
                        result.select_active = 1'b1;
                    end
                end
                default: begin
                    result.status = STATUS_UNEXPECTED;
                end
            endcase
        end
    end

    // Advance the sequencer on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            addr_reg  <= '0;
            len_reg   <= '0;
            inv_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            len_reg   <= len_next;
            inv_reg   <= inv_next;
        end
    end

    frgf_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .has_room  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

### bench/tb_font_rom_glyph_fetch_core.sv
`timescale 1ns / 100ps

module tb_font_rom_glyph_fetch_core;
    import frgf_pkg::*;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 4000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    // Pacing of both channels, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int n_errors      = 0;
    int n_results     = 0;
    int n_glyph_bytes = 0;
    int n_glyphs      = 0;
    int n_invalid     = 0;
    int n_ignored     = 0;
    int n_counted     = 0;

    out_item_t glyph_expected_q[$];

    // Shadow of the sequencer and its base registers
    phase_t             seq_phase  = PH_IDLE;
    logic [COUNT_W-1:0] seq_count  = '0;
    logic [ADDR_W-1:0]  seq_addr   = '0;
    logic [COUNT_W-1:0] seq_len    = '0;
    logic               seq_invert = 1'b0;
    base_bank_t         font_base  = '0;

    font_rom_glyph_fetch_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    // Withhold m_ready at random while the receiver is stalling
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Work out the result of one accepted item and advance the shadow state
    function automatic out_item_t glyph_fetch_predict(input in_item_t it);
        out_item_t          r;
        logic [7:0]         hi;
        logic [7:0]         lo;
        logic               found;
        int unsigned        index;
        logic [COUNT_W-1:0] len;
        logic [COUNT_W-1:0] nxt;
        r  = '0;
        hi = it.first_byte;
        lo = it.second_byte;
        if (it.cmd == CMD_REQUEST) begin
            if (seq_phase != PH_IDLE) begin
                r.status        = STATUS_UNEXPECTED;
                r.select_active = 1'b1;
                return r;
            end
            found = 1'b1;
            index = 0;
            len   = LEN_GB;
            if (it.font_select == FONT_GB2312_16) begin
                if (lo < GB_LO_MIN) begin
                    found = 1'b0;
                end else if (hi == GB_EXT_ROW) begin
                    index = GB_EXT_START + (lo - GB_LO_MIN);
                end else if (hi >= GB_SYM_FIRST && hi <= GB_SYM_LAST) begin
                    index = (hi - GB_SYM_FIRST) * GB_ROW_LEN + (lo - GB_LO_MIN);
                end else if (hi >= GB_HZ_FIRST && hi <= GB_HZ_LAST) begin
                    index = (hi - GB_HZ_FIRST) * GB_ROW_LEN + (lo - GB_LO_MIN) + GB_HZ_START;
                end else begin
                    found = 1'b0;
                end
            end else if (it.font_select <= FONT_ASCII_BOLD) begin
                len = (it.font_select <= FONT_ASCII_7X8) ? LEN_SMALL : LEN_LARGE;
                if (hi < ASCII_FIRST || hi > ASCII_LAST) begin
                    found = 1'b0;
                end else begin
                    index = hi - ASCII_FIRST;
                end
            end else begin
                found = 1'b0;
            end
            if (!found) begin
                r.status = STATUS_INVALID;
                return r;
            end
            // Address wraps at 24 bits
            seq_addr   = ADDR_W'(font_base[it.font_select] + index * len);
            seq_len    = len;
            seq_invert = it.invert;
            seq_count  = '0;
            seq_phase  = PH_HEADER;
            r.tx_valid      = 1'b1;
            r.tx_byte       = FLASH_READ_CMD;
            r.select_active = 1'b1;
            return r;
        end
        case (seq_phase)
            PH_HEADER: begin
                r.tx_valid      = 1'b1;
                r.select_active = 1'b1;
                if (seq_count < 3) begin
                    // Address bytes go out high first
                    r.tx_byte = seq_addr[8 * (2 - seq_count) +: 8];
                    seq_count = seq_count + 1'b1;
                end else begin
                    r.tx_byte = FLASH_DUMMY;
                    seq_count = '0;
                    seq_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                r.data_valid = 1'b1;
                r.glyph_byte = seq_invert ? ~it.rx_byte : it.rx_byte;
                nxt = seq_count + 1'b1;
                if (nxt >= seq_len) begin
                    seq_phase = PH_IDLE;
                    seq_count = '0;
                    r.last    = 1'b1;
                end else begin
                    seq_count       = nxt;
                    r.tx_valid      = 1'b1;
                    r.tx_byte       = FLASH_DUMMY;
                    r.select_active = 1'b1;
                end
            end
            default: begin
                // Stray byte while idle
                seq_phase = PH_IDLE;
                r.status  = STATUS_UNEXPECTED;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fname, want, got);
            n_errors++;
        end
    endtask

    // Compare each delivered item with the oldest prediction
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (glyph_expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual 0x%h", $time, m_data);
                n_errors++;
            end else begin
                want = glyph_expected_q.pop_front();
                check_field("status", want.status, m_data.status);
                check_field("tx_valid", want.tx_valid, m_data.tx_valid);
                check_field("tx_byte", want.tx_byte, m_data.tx_byte);
                check_field("select_active", want.select_active, m_data.select_active);
                check_field("data_valid", want.data_valid, m_data.data_valid);
                check_field("glyph_byte", want.glyph_byte, m_data.glyph_byte);
                check_field("last", want.last, m_data.last);
                n_results++;
                if (want.data_valid) n_glyph_bytes++;
                if (want.last) n_glyphs++;
                if (want.status == STATUS_INVALID) n_invalid++;
                if (want.status == STATUS_UNEXPECTED) n_ignored++;
            end
        end
    end

    // Offer one item, hold it until accepted, then record its prediction
    task automatic send_item(input in_item_t it);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = glyph_fetch_predict(it);
        glyph_expected_q.push_back(predicted);
        if (predicted.status != STATUS_UNEXPECTED) n_counted++;
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_for_results();
        int waited;
        s_valid <= 1'b0;
        waited = 0;
        while (glyph_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (glyph_expected_q.size() != 0) begin
            $display("%0t: %0d results missing: expected 0x%h first, actual none",
                     $time, glyph_expected_q.size(), glyph_expected_q[0]);
            n_errors++;
            glyph_expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_font_bases(input base_bank_t bank);
        for (int i = 0; i < NUM_FONTS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= bank[i];
            @(posedge aclk);
            font_base[i] = bank[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic in_item_t mk_item(input logic cmd, input logic [FONT_W-1:0] font,
                                         input logic [7:0] hi, input logic [7:0] lo,
                                         input logic inv, input logic [7:0] rx);
        in_item_t it;
        it.cmd         = cmd;
        it.font_select = font;
        it.first_byte  = hi;
        it.second_byte = lo;
        it.invert      = inv;
        it.rx_byte     = rx;
        return it;
    endfunction

    function automatic in_item_t random_item();
        logic [$bits(in_item_t)-1:0] raw;
        raw = $bits(in_item_t)'($urandom);
        return in_item_t'(raw);
    endfunction

    function automatic in_item_t flash_rx_item();
        in_item_t it;
        it     = random_item();
        it.cmd = CMD_RX_BYTE;
        return it;
    endfunction

    // Valid request, leaning on the corners of each code range
    function automatic in_item_t glyph_request();
        in_item_t it;
        it             = random_item();
        it.cmd         = CMD_REQUEST;
        it.font_select = FONT_W'($urandom_range(FONT_ASCII_BOLD));
        if (it.font_select == FONT_GB2312_16) begin
            case ($urandom_range(6))
                0: it.first_byte = BYTE_W'($urandom_range(GB_SYM_LAST, GB_SYM_FIRST));
                1: it.first_byte = $urandom_range(1) ? GB_SYM_FIRST : GB_SYM_LAST;
                2: it.first_byte = GB_EXT_ROW;
                3: it.first_byte = $urandom_range(1) ? GB_HZ_FIRST : GB_HZ_LAST;
                default: it.first_byte = BYTE_W'($urandom_range(GB_HZ_LAST, GB_HZ_FIRST));
            endcase
            case ($urandom_range(3))
                0: it.second_byte = GB_LO_MIN;
                1: it.second_byte = 8'hFF;
                default: it.second_byte = BYTE_W'($urandom_range(255, GB_LO_MIN));
            endcase
        end else begin
            case ($urandom_range(3))
                0: it.first_byte = ASCII_FIRST;
                1: it.first_byte = ASCII_LAST;
                default: it.first_byte = BYTE_W'($urandom_range(ASCII_LAST, ASCII_FIRST));
            endcase
        end
        return it;
    endfunction

    // Request that falls outside every code range or names no font
    function automatic in_item_t rejected_request();
        in_item_t it;
        it     = random_item();
        it.cmd = CMD_REQUEST;
        case ($urandom_range(3))
            0: it.font_select = FONT_W'($urandom_range(7, FONT_ASCII_BOLD + 1));
            1: begin
                it.font_select = FONT_GB2312_16;
                it.second_byte = BYTE_W'($urandom_range(GB_LO_MIN - 1));
            end
            2: begin
                it.font_select = FONT_GB2312_16;
                it.second_byte = BYTE_W'($urandom_range(255, GB_LO_MIN));
                case ($urandom_range(3))
                    0: it.first_byte = BYTE_W'($urandom_range(GB_SYM_FIRST - 1));
                    1: it.first_byte = BYTE_W'($urandom_range(GB_EXT_ROW - 1, GB_SYM_LAST + 1));
                    2: it.first_byte = BYTE_W'($urandom_range(GB_HZ_FIRST - 1, GB_EXT_ROW + 1));
                    default: it.first_byte = BYTE_W'($urandom_range(255, GB_HZ_LAST + 1));
                endcase
            end
            default: begin
                it.font_select = FONT_W'($urandom_range(FONT_ASCII_BOLD, FONT_ASCII_5X7));
                it.first_byte  = BYTE_W'($urandom_range(1) ? $urandom_range(ASCII_FIRST - 1)
                                                           : $urandom_range(255, ASCII_LAST + 1));
            end
        endcase
        return it;
    endfunction

    function automatic base_bank_t pick_bases(input int mode);
        base_bank_t bank;
        for (int i = 0; i < NUM_FONTS; i++) begin
            case (mode)
                0: bank[i] = '1;
                1: bank[i] = '0;
                2: bank[i] = ADDR_W'($urandom);
                default: bank[i] = {8'hFF, 16'($urandom)};
            endcase
        end
        return bank;
    endfunction

    // Mixed bases, the 5x7 table at the very top so its glyphs wrap
    task automatic test_base_registers();
        base_bank_t bank;
        bank[FONT_GB2312_16]  = 24'h000000;
        bank[FONT_ASCII_5X7]  = 24'hFFFFFF;
        bank[FONT_ASCII_7X8]  = 24'h800000;
        bank[FONT_ASCII_8X16] = 24'h7FFFFF;
        bank[FONT_ASCII_BOLD] = 24'h123456;
        write_font_bases(bank);
    endtask

    // Stray byte while idle, unknown fonts and codes just outside each range
    task automatic test_rejected_requests();
        send_item(mk_item(CMD_RX_BYTE, FONT_GB2312_16, 8'h00, 8'h00, 1'b0, 8'hFF));
        send_item(mk_item(CMD_REQUEST, 3'd5, 8'h41, 8'hA1, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, 3'd7, 8'hB0, 8'hA1, 1'b1, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_GB2312_16, 8'hB0, 8'hA0, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_GB2312_16, 8'hA4, 8'hA1, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_GB2312_16, 8'hAF, 8'hFF, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_GB2312_16, 8'hF8, 8'hA1, 1'b1, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_ASCII_5X7, 8'h1F, 8'h00, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_ASCII_BOLD, 8'h80, 8'h00, 1'b0, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_ASCII_8X16, 8'hFF, 8'hFF, 1'b1, 8'h00));
    endtask

    // Inverted 5x7 glyph with a wrapping address, interrupted by busy requests
    task automatic test_interrupted_transfer();
        logic [7:0] pattern [8];
        pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
        send_item(mk_item(CMD_REQUEST, FONT_ASCII_5X7, 8'h7F, 8'h00, 1'b1, 8'h00));
        send_item(mk_item(CMD_REQUEST, FONT_GB2312_16, 8'hA1, 8'hA1, 1'b0, 8'h00));
        repeat (4) send_item(flash_rx_item());
        send_item(mk_item(CMD_REQUEST, FONT_ASCII_8X16, 8'h20, 8'h00, 1'b0, 8'h00));
        foreach (pattern[i]) begin
            send_item(mk_item(CMD_RX_BYTE, FONT_GB2312_16, 8'h00, 8'h00, 1'b0, pattern[i]));
        end
    endtask

    // Mostly complete glyph fetches with random content, plus noise
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input base_bank_t bank);
        int target;
        wait_for_results();
        write_font_bases(bank);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = n_counted + RANDOM_ITEMS / 4;
        while (n_counted < target) begin
            case ($urandom_range(19))
                0, 1: send_item(rejected_request());
                2: send_item(flash_rx_item());
                default: begin
                    send_item(glyph_request());
                    while (seq_phase != PH_IDLE) begin
                        if ($urandom_range(24) == 0) begin
                            send_item($urandom_range(1) ? glyph_request() : rejected_request());
                        end
                        send_item(flash_rx_item());
                    end
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_base_registers();
        test_rejected_requests();
        test_interrupted_transfer();
        test_random_traffic(0, 0, pick_bases(0));
        test_random_traffic(62, 0, pick_bases(1));
        test_random_traffic(0, 62, pick_bases(2));
        test_random_traffic(27, 27, pick_bases(3));
        wait_for_results();
        $display("Checked %0d results: %0d glyph bytes over %0d glyphs, %0d rejected requests,",
                 n_results, n_glyph_bytes, n_glyphs, n_invalid);
        $display("%0d ignored items, under four pacing modes and five sets of base addresses.",
                 n_ignored);
        if (n_errors == 0) begin
            $display("font_rom_glyph_fetch_core verification clean");
        end else begin
            $display("font_rom_glyph_fetch_core verification failed");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("%0t: run timed out", $time);
        $display("font_rom_glyph_fetch_core verification failed");
        $finish;
    end

endmodule

### filelist.f
src/frgf_pkg.sv
src/frgf_lookup.sv
src/frgf_out_buf.sv
src/font_rom_glyph_fetch_core.sv
bench/tb_font_rom_glyph_fetch_core.sv
